@@ src/mer_pkg.sv @@
// shared types and constants of the midpoint ellipse rasterizer
// no dependencies; imported by the controller, the datapath and the top level
package mer_pkg;

   // default widths of the radius and centre fields
   localparam int RADIUS_BITS_DEF = 10;
   localparam int COORD_BITS_DEF  = 12;

   // request kinds carried on req_tuser
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // operand pairs of the shared multiplier
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_RX_RX,
      MUL_RY_RY,
      MUL_RX2_Y,
      MUL_TX_TX,
      MUL_YM_YM,
      MUL_TMP_RY2,
      MUL_TMP_RX2,
      MUL_RX2_RY2
   } mul_sel_type;

   // where the registered product goes
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_RX2,
      ACC_RY2,
      ACC_INIT,
      ACC_TMP,
      ACC_SW_SET,
      ACC_SW_ADD,
      ACC_SW_SUB
   } acc_op_type;

   // controller to datapath
   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        pt_load;
      logic [1:0]  pt_idx;
      logic        step;
      logic        clr_active;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic active;
      logic need_switch;
      logic done;
   } dp_status_type;

endpackage

@@ src/mer_ctrl.sv @@
// controller of the midpoint ellipse rasterizer: sequences start, region switch and emission
// depends on mer_pkg for the command and status structs
module mer_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_op,
   output logic                   req_tready,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   input  mer_pkg::dp_status_type status,
   output mer_pkg::dp_cmd_type    cmd
);
   import mer_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RX,
      ST_SQ_RY,
      ST_MUL_RY,
      ST_INIT,
      ST_W1,
      ST_W2,
      ST_W3,
      ST_W4,
      ST_W5,
      ST_W6,
      ST_PREP,
      ST_EMIT
   } state_type;

   localparam logic [1:0] IDX_LAST = 2'd3;

   state_type  state_ff, state_in;
   logic       ready_ff, ready_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      ready_in       = ready_ff;
      valid_in       = valid_ff;
      idx_in         = idx_ff;
      cmd            = '0;
      cmd.mul_sel    = MUL_NONE;
      cmd.acc_op     = ACC_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               if (req_op == OP_START) begin
                  cmd.load = 1'b1;
                  ready_in = 1'b0;
                  state_in = ST_SQ_RX;
               end else if (status.active) begin
                  ready_in = 1'b0;
                  state_in = status.need_switch ? ST_W1 : ST_PREP;
               end
            end
         end
         ST_SQ_RX: begin
            cmd.mul_sel = MUL_RX_RX;
            state_in    = ST_SQ_RY;
         end
         ST_SQ_RY: begin
            cmd.acc_op  = ACC_RX2;
            cmd.mul_sel = MUL_RY_RY;
            state_in    = ST_MUL_RY;
         end
         ST_MUL_RY: begin
            cmd.acc_op  = ACC_RY2;
            cmd.mul_sel = MUL_RX2_Y;
            state_in    = ST_INIT;
         end
         ST_INIT: begin
            cmd.acc_op = ACC_INIT;
            ready_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         // region two start value, one product a cycle
         ST_W1: begin
            cmd.mul_sel = MUL_TX_TX;
            state_in    = ST_W2;
         end
         ST_W2: begin
            cmd.acc_op  = ACC_TMP;
            cmd.mul_sel = MUL_YM_YM;
            state_in    = ST_W3;
         end
         ST_W3: begin
            cmd.acc_op  = ACC_TMP;
            cmd.mul_sel = MUL_TMP_RY2;
            state_in    = ST_W4;
         end
         ST_W4: begin
            cmd.acc_op  = ACC_SW_SET;
            cmd.mul_sel = MUL_TMP_RX2;
            state_in    = ST_W5;
         end
         ST_W5: begin
            cmd.acc_op  = ACC_SW_ADD;
            cmd.mul_sel = MUL_RX2_RY2;
            state_in    = ST_W6;
         end
         ST_W6: begin
            cmd.acc_op = ACC_SW_SUB;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.pt_load = 1'b1;
            cmd.pt_idx  = 2'd0;
            idx_in      = 2'd0;
            valid_in    = 1'b1;
            state_in    = ST_EMIT;
         end
         // four points, then step or finish
         ST_EMIT: begin
            if (rsp_tready) begin
               if (idx_ff == IDX_LAST) begin
                  cmd.step       = !status.done;
                  cmd.clr_active = status.done;
                  valid_in       = 1'b0;
                  ready_in       = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.pt_load = 1'b1;
                  cmd.pt_idx  = idx_ff + 2'd1;
                  idx_in      = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
            valid_in = 1'b0;
         end
      endcase
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

@@ src/mer_dpath.sv @@
// datapath of the midpoint ellipse rasterizer: shared multiplier, decision, position, points
// depends on mer_pkg for the command and status structs and the operation codes
module mer_dpath #(
   parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mer_pkg::dp_cmd_type       cmd,
   output mer_pkg::dp_status_type    status,
   input  logic [RADIUS_BITS-1:0]    ld_radius_x,
   input  logic [RADIUS_BITS-1:0]    ld_radius_y,
   input  logic [COORD_BITS-1:0]     ld_centre_x,
   input  logic [COORD_BITS-1:0]     ld_centre_y,
   output logic [COORD_BITS+1:0]     pt_x,
   output logic [COORD_BITS+1:0]     pt_y,
   output logic                      pt_last,
   output logic                      pt_done
);
   import mer_pkg::*;

   localparam int R        = RADIUS_BITS;
   localparam int C        = COORD_BITS;
   localparam int PT       = C + 2;
   localparam int OW       = R + 1;
   localparam int EW       = PT + OW;
   localparam int SQ       = 2 * R;
   localparam int MA       = 2 * R + 4;
   localparam int MB       = 2 * R;
   localparam int PROD     = MA + MB;
   localparam int DEC_BITS = (4 * R + 8 > 64) ? 64 : 4 * R + 8;
   localparam int EXT      = PROD + DEC_BITS;
   localparam int PXY      = 3 * R + 3;
   localparam logic [1:0] IDX_LAST = 2'd3;

   logic [R-1:0]        rx_ff, ry_ff;
   logic [C-1:0]        cx_ff, cy_ff;
   logic [SQ-1:0]       rx2_ff, ry2_ff;
   logic [OW-1:0]       x_ff, y_ff;
   logic [PXY-1:0]      px_ff, py_ff;
   logic [DEC_BITS-1:0] dec_ff;
   logic [MA-1:0]       tmp_ff;
   logic [PROD-1:0]     prod_ff;
   logic                in_r2_ff, active_ff;
   logic [PT-1:0]       pt_x_ff, pt_y_ff;
   logic                pt_last_ff, pt_done_ff;

   logic [MA-1:0]       mul_a;
   logic [MB-1:0]       mul_b;
   logic [R+1:0]        tx1;
   logic [OW-1:0]       ym1;
   logic [EXT-1:0]      prod_ext;
   logic [DEC_BITS-1:0] prod_dec;
   logic [PXY-1:0]      px_inc, py_dec;
   logic [DEC_BITS-1:0] px4, py4, rx2_4, ry2_4, delta;
   logic                dec_neg, dec_pos, x_step, y_step;
   logic                mx, my;

   // centre plus or minus offset, wrapped to the point width
   function automatic logic [PT-1:0] point_of(input logic [C-1:0] centre,
                                              input logic [OW-1:0] offset,
                                              input logic minus);
      logic [EW-1:0] ce;
      logic [EW-1:0] oe;
      logic [EW-1:0] v;
      ce = EW'(centre);
      oe = EW'(offset);
      v  = minus ? (ce - oe) : (ce + oe);
      return v[PT-1:0];
   endfunction

   // status toward the controller
   assign status.active      = active_ff;
   assign status.need_switch = !in_r2_ff && !(px_ff < py_ff);
   assign status.done        = in_r2_ff && (y_ff == '0);

   assign pt_x    = pt_x_ff;
   assign pt_y    = pt_y_ff;
   assign pt_last = pt_last_ff;
   assign pt_done = pt_done_ff;

   // multiplier operand selection
   assign tx1 = {x_ff, 1'b1};
   assign ym1 = (y_ff == '0) ? OW'(1) : (y_ff - OW'(1));

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_RX_RX: begin
            mul_a = MA'(rx_ff);
            mul_b = MB'(rx_ff);
         end
         MUL_RY_RY: begin
            mul_a = MA'(ry_ff);
            mul_b = MB'(ry_ff);
         end
         MUL_RX2_Y: begin
            mul_a = MA'(rx2_ff);
            mul_b = MB'(y_ff);
         end
         MUL_TX_TX: begin
            mul_a = MA'(tx1);
            mul_b = MB'(tx1);
         end
         MUL_YM_YM: begin
            mul_a = MA'(ym1);
            mul_b = MB'(ym1);
         end
         MUL_TMP_RY2: begin
            mul_a = tmp_ff;
            mul_b = ry2_ff;
         end
         MUL_TMP_RX2: begin
            mul_a = tmp_ff;
            mul_b = rx2_ff;
         end
         MUL_RX2_RY2: begin
            mul_a = MA'(rx2_ff);
            mul_b = ry2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // product wrapped to the decision width
   assign prod_ext = EXT'(prod_ff);
   assign prod_dec = prod_ext[DEC_BITS-1:0];

   // incremental terms of one step
   assign px_inc  = px_ff + PXY'({ry2_ff, 1'b0});
   assign py_dec  = py_ff - PXY'({rx2_ff, 1'b0});
   assign px4     = DEC_BITS'(px_inc) << 2;
   assign py4     = DEC_BITS'(py_dec) << 2;
   assign rx2_4   = DEC_BITS'(rx2_ff) << 2;
   assign ry2_4   = DEC_BITS'(ry2_ff) << 2;
   assign dec_neg = dec_ff[DEC_BITS-1];
   assign dec_pos = !dec_neg && (dec_ff != '0);

   always_comb begin
      unique case ({in_r2_ff, in_r2_ff ? dec_pos : dec_neg})
         2'b00: begin
            x_step = 1'b1;
            y_step = 1'b1;
            delta  = px4 - py4 + ry2_4;
         end
         2'b01: begin
            x_step = 1'b1;
            y_step = 1'b0;
            delta  = px4 + ry2_4;
         end
         2'b11: begin
            x_step = 1'b0;
            y_step = 1'b1;
            delta  = rx2_4 - py4;
         end
         default: begin
            x_step = 1'b1;
            y_step = 1'b1;
            delta  = px4 - py4 + rx2_4;
         end
      endcase
   end

   // symmetric point select
   assign mx = (cmd.pt_idx == 2'd2) || (cmd.pt_idx == IDX_LAST);
   assign my = (cmd.pt_idx == 2'd1) || (cmd.pt_idx == 2'd2);

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         in_r2_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            active_ff <= 1'b1;
            in_r2_ff  <= 1'b0;
         end else begin
            if (cmd.clr_active) begin
               active_ff <= 1'b0;
            end
            if (cmd.acc_op == ACC_SW_SUB) begin
               in_r2_ff <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= PROD'(mul_a * mul_b);
      if (cmd.load) begin
         rx_ff <= ld_radius_x;
         ry_ff <= ld_radius_y;
         cx_ff <= ld_centre_x;
         cy_ff <= ld_centre_y;
         x_ff  <= '0;
         y_ff  <= OW'(ld_radius_y);
         px_ff <= '0;
      end
      unique case (cmd.acc_op)
         ACC_RX2:    rx2_ff <= prod_ff[SQ-1:0];
         ACC_RY2:    ry2_ff <= prod_ff[SQ-1:0];
         ACC_INIT: begin
            dec_ff <= ry2_4 + DEC_BITS'(rx2_ff) - (prod_dec << 2);
            py_ff  <= PXY'({prod_ff, 1'b0});
         end
         ACC_TMP:    tmp_ff <= prod_ff[MA-1:0];
         ACC_SW_SET: dec_ff <= prod_dec;
         ACC_SW_ADD: dec_ff <= dec_ff + (prod_dec << 2);
         ACC_SW_SUB: dec_ff <= dec_ff - (prod_dec << 2);
         default: begin
         end
      endcase
      // one rasterizer step after the last point of a request
      if (cmd.step) begin
         dec_ff <= dec_ff + delta;
         if (x_step) begin
            x_ff  <= x_ff + OW'(1);
            px_ff <= px_inc;
         end
         if (y_step) begin
            y_ff  <= y_ff - OW'(1);
            py_ff <= py_dec;
         end
      end
      // output point register
      if (cmd.pt_load) begin
         pt_x_ff    <= point_of(cx_ff, x_ff, mx);
         pt_y_ff    <= point_of(cy_ff, y_ff, my);
         pt_last_ff <= (cmd.pt_idx == IDX_LAST);
         pt_done_ff <= in_r2_ff && (y_ff == '0);
      end
   end

endmodule

@@ src/midpoint_ellipse_rasterizer_core.sv @@
// top level of the midpoint ellipse rasterizer: stream ports, controller and datapath
// depends on mer_pkg, mer_ctrl and mer_dpath
//
//   channel   direction  handshake              contents
//   req       in         req_tvalid/req_tready  tuser: operation; tdata: radii, centre
//   rsp       out        rsp_tvalid/rsp_tready  tdata: point x, y; tlast: last of step;
//                                               tuser: done
//
// a start request runs three multiplier passes and the seed and gives no points
// an advance request with a ready consumer runs accept, point load, four points
// the first advance in region two also runs the multiplier passes of its start value
// the multiplier is shared and points leave one per cycle unless rsp stalls, which hold the point
// reset is synchronous and clears the controller and the active and region flags
module midpoint_ellipse_rasterizer_core #(
   parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // radius_x, radius_y, centre_x, centre_y from bit 0 up, zero padded to bytes
   input  logic [((2 * RADIUS_BITS + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // operation
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // point_x, point_y from bit 0 up, zero padded to bytes
   output logic [((2 * (COORD_BITS + 2) + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic rsp_tlast,
   // done_res
   output logic [0:0] rsp_tuser
);
   import mer_pkg::*;

   localparam int R        = RADIUS_BITS;
   localparam int C        = COORD_BITS;
   localparam int PT       = C + 2;
   localparam int RSP_BITS = ((2 * PT + 7) / 8) * 8;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [PT-1:0] pt_x, pt_y;
   logic          pt_last, pt_done;

   mer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   mer_dpath #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .ld_radius_x (req_tdata[R-1:0]),
      .ld_radius_y (req_tdata[2*R-1:R]),
      .ld_centre_x (req_tdata[2*R+C-1:2*R]),
      .ld_centre_y (req_tdata[2*R+2*C-1:2*R+C]),
      .pt_x        (pt_x),
      .pt_y        (pt_y),
      .pt_last     (pt_last),
      .pt_done     (pt_done)
   );

   assign rsp_tdata    = RSP_BITS'({pt_y, pt_x});
   assign rsp_tlast    = pt_last;
   assign rsp_tuser[0] = pt_done;

   // no request is taken while points are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("request accepted while points pending");

   // the position steps only on the accepted fourth point
   a_step_on_last: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (rsp_tvalid && rsp_tready && rsp_tlast))
      else $error("step without final point handshake");

   // points of one step follow without a gap
   a_points_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a step");

   // a new ellipse loads only from an accepted start request
   a_load_on_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_tvalid && req_tready && (req_tuser[0] == OP_START)))
      else $error("load without start request");

endmodule

@@ bench/testbench.sv @@
// self-checking bench for midpoint_ellipse_rasterizer_core: directed and random ellipse requests
// depends on mer_pkg and the rasterizer rtl; keeps its own ellipse model to predict every point
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mer_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int REPORT_MAX     = 10;

   // one plotted point as it leaves the rsp channel
   typedef struct packed {
      logic [13:0] px;
      logic [13:0] py;
      logic        last;
      logic        done;
   } plot_point_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;

   // expected points, oldest first
   plot_point_type expected_points[$];
   int             mismatch_count = 0;
   int             stall_count = 0;
   int             req_idle_pct;
   int             rsp_idle_pct;

   // model of the ellipse walk
   logic [31:0] ell_x;
   logic [31:0] ell_y;
   logic [63:0] ell_decision;
   logic        ell_region_two;
   logic        ell_active;
   logic [9:0]  ell_rx;
   logic [9:0]  ell_ry;
   logic [11:0] ell_cx;
   logic [11:0] ell_cy;

   plot_point_type got_pt;
   plot_point_type want_pt;

   midpoint_ellipse_rasterizer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // centre plus or minus offset, wrapped to the point width
   function automatic logic [13:0] point_coord(input logic [11:0] centre,
                                               input logic [31:0] offset,
                                               input logic minus);
      logic [31:0] sum;
      sum = minus ? (32'(centre) - offset) : (32'(centre) + offset);
      return sum[13:0];
   endfunction

   // update the ellipse model with one accepted request and queue its points
   task automatic plot_request(input logic op, input logic [9:0] rx, input logic [9:0] ry,
                               input logic [11:0] cx, input logic [11:0] cy);
      logic [63:0]    rx2, ry2, px, py, ym1, tx1;
      logic           done_now;
      plot_point_type pt;
      if (op == OP_START) begin
         ell_rx = rx;
         ell_ry = ry;
         ell_cx = cx;
         ell_cy = cy;
         rx2 = 64'(rx);
         rx2 = rx2 * rx2;
         ry2 = 64'(ry);
         ry2 = ry2 * ry2;
         py = 64'(ry);
         ell_x = 32'd0;
         ell_y = 32'(ry);
         ell_decision = 4 * ry2 - 4 * rx2 * py + rx2;
         ell_region_two = 1'b0;
         ell_active = 1'b1;
      end else if (ell_active) begin
         rx2 = 64'(ell_rx);
         rx2 = rx2 * rx2;
         ry2 = 64'(ell_ry);
         ry2 = ry2 * ry2;
         px = 64'(ell_x);
         py = 64'(ell_y);
         // slope passes -1: reseed the decision for region two
         if (!ell_region_two && !(ry2 * px < rx2 * py)) begin
            ym1 = py - 1;
            tx1 = 2 * px + 1;
            ell_decision = tx1 * tx1 * ry2 + 4 * ym1 * ym1 * rx2 - 4 * rx2 * ry2;
            ell_region_two = 1'b1;
         end
         done_now = ell_region_two && (py == 0);
         // four symmetric points
         for (int k = 0; k < 4; k++) begin
            pt.px   = point_coord(ell_cx, ell_x, k >= 2);
            pt.py   = point_coord(ell_cy, ell_y, k == 1 || k == 2);
            pt.last = (k == 3);
            pt.done = done_now;
            expected_points.push_back(pt);
         end
         if (done_now) begin
            ell_active = 1'b0;
         end else begin
            // step the decision
            if (!ell_region_two) begin
               if (ell_decision[63]) begin
                  px = px + 1;
                  ell_decision = ell_decision + 4 * ry2 + 8 * ry2 * px;
               end else begin
                  px = px + 1;
                  py = py - 1;
                  ell_decision = ell_decision + 8 * ry2 * px - 8 * rx2 * py + 4 * ry2;
               end
            end else begin
               if (!ell_decision[63] && ell_decision != 0) begin
                  py = py - 1;
                  ell_decision = ell_decision + 4 * rx2 - 8 * rx2 * py;
               end else begin
                  px = px + 1;
                  py = py - 1;
                  ell_decision = ell_decision + 8 * ry2 * px - 8 * rx2 * py + 4 * rx2;
               end
            end
            ell_x = px[31:0];
            ell_y = py[31:0];
         end
      end
   endtask

   // drive one request, wait for its handshake, then predict it
   task automatic send_request(input logic op, input logic [9:0] rx, input logic [9:0] ry,
                               input logic [11:0] cx, input logic [11:0] cy);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, cy, cx, ry, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      plot_request(op, rx, ry, cx, cy);
   endtask

   // advance request with random content in the ignored fields
   task automatic send_advance();
      send_request(OP_ADVANCE, 10'($urandom), 10'($urandom), 12'($urandom), 12'($urandom));
   endtask

   // advance before any ellipse is loaded gives nothing
   task automatic test_no_ellipse();
      send_advance();
   endtask

   // largest radii and centres, negative coordinates, restart while drawing
   task automatic test_extreme_values();
      send_request(OP_START, 10'd1023, 10'd1023, 12'd4095, 12'd4095);
      repeat (2) send_advance();
      send_request(OP_START, 10'd1023, 10'd1, 12'd0, 12'd0);
      repeat (2) send_advance();
   endtask

   // zero radii: vertical segment and single centre point, then advances past done
   task automatic test_zero_radius();
      send_request(OP_START, 10'd0, 10'd3, 12'd100, 12'd200);
      repeat (5) send_advance();
      send_request(OP_START, 10'd5, 10'd0, 12'd7, 12'd9);
      repeat (2) send_advance();
   endtask

   // unit circle drawn to the end
   task automatic test_small_ellipse();
      send_request(OP_START, 10'd1, 10'd1, 12'd4095, 12'd0);
      repeat (4) send_advance();
   endtask

   // random ellipses, mostly small and drawn to the end, some cut short or large
   task automatic test_random_ellipses(input int n_items);
      int          sent;
      int          n_adv;
      int          pick;
      logic [9:0]  rx;
      logic [9:0]  ry;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            rx = 10'($urandom);
            ry = 10'($urandom);
            n_adv = $urandom_range(6, 2);
         end else begin
            rx = 10'($urandom_range(12));
            ry = 10'($urandom_range(12));
            if (pick < 85) n_adv = rx + ry + 2;
            else n_adv = $urandom_range(rx + ry);
         end
         // stray advance with no fresh ellipse now and then
         if ($urandom_range(99) < 8) begin
            send_advance();
            sent++;
         end
         send_request(OP_START, rx, ry, 12'($urandom), 12'($urandom));
         sent++;
         repeat (n_adv) begin
            send_advance();
            sent++;
         end
      end
   endtask

   // random stalls on the result side
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // compare each accepted point with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_pt.px   = rsp_tdata[13:0];
         got_pt.py   = rsp_tdata[27:14];
         got_pt.last = rsp_tlast;
         got_pt.done = rsp_tuser[0];
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected point: x=%0d y=%0d last=%0b done=%0b",
                        $signed(got_pt.px), $signed(got_pt.py), got_pt.last, got_pt.done);
         end else begin
            want_pt = expected_points.pop_front();
            if (got_pt.px != want_pt.px || got_pt.py != want_pt.py ||
                got_pt.last != want_pt.last || got_pt.done != want_pt.done) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("point mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                           $signed(want_pt.px), $signed(want_pt.py), want_pt.last,
                           want_pt.done, $signed(got_pt.px), $signed(got_pt.py),
                           got_pt.last, got_pt.done);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // test sequence
   initial begin
      req_idle_pct   = 20;
      rsp_idle_pct   = 75;
      ell_x          = 32'd0;
      ell_y          = 32'd0;
      ell_decision   = 64'd0;
      ell_region_two = 1'b0;
      ell_active     = 1'b0;
      ell_rx         = 10'd0;
      ell_ry         = 10'd0;
      ell_cx         = 12'd0;
      ell_cy         = 12'd0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 48'd0;
      req_tuser  <= OP_START;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_ellipse();
      test_extreme_values();
      test_zero_radius();
      test_small_ellipse();
      test_random_ellipses(25);

      req_idle_pct = 75;
      rsp_idle_pct = 20;
      test_random_ellipses(25);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_ellipses(25);

      // drain
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
